/* rtl/core/isp_pkg.sv */
// Shared types and constants for the isomorphic string pair checker.
// Used by the map memories and the top level; no dependencies.
package isp_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CHAR_VALUES = 256;
  localparam int unsigned EPOCH_W     = 8;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  // Epoch zero never matches: the clearing pass writes it into every entry.
  localparam epoch_t EPOCH_NONE  = '0;
  localparam epoch_t EPOCH_FIRST = epoch_t'(1);
  localparam epoch_t EPOCH_LAST  = '1;

  typedef struct packed {
    epoch_t epoch;
    char_t  partner;
  } map_entry_t;

endpackage

/* rtl/core/isomorphic_string_pair_check.sv */
// Isomorphic string pair checker: takes one aligned character pair per item and
// gives one verdict item on the pair marked last. Sustains one item per cycle when
// not stalled: the table read is issued at accept and checked and written back in
// the next cycle, with the previous write forwarded. Map entries carry an epoch
// tag instead of valid bits. After reset, and again after every 255 completed
// strings, a clearing pass rewrites all tags while input is stalled; the wrap
// pass waits for the last item to leave the check stage.
// Depends on isp_pkg, isp_map_mem and isp_out_queue.
module isomorphic_string_pair_check import isp_pkg::*; #(
  parameter int unsigned SYMBOLS = 256
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  char_t src_char_i,
  input  char_t dst_char_i,
  input  logic  last_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output logic  is_isomorphic_o
);

  localparam int unsigned IDX_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam logic [IDX_W-1:0] IDX_END = IDX_W'(SYMBOLS - 1);

  // character to table index, modulo SYMBOLS
  logic [IDX_W-1:0] idx_lut [CHAR_VALUES];
  for (genvar g = 0; g < CHAR_VALUES; g++) begin : g_idx
    assign idx_lut[g] = IDX_W'(g % SYMBOLS);
  end

  logic             in_acc;
  logic             q_room;

  // check stage
  logic             s1_vld_q;
  char_t            s1_src_q, s1_dst_q;
  logic             s1_last_q;
  logic [IDX_W-1:0] s1_fidx_q, s1_ridx_q;

  // last write, forwarded to the next item
  logic             wb_vld_q;
  logic [IDX_W-1:0] wb_fidx_q, wb_ridx_q;
  map_entry_t       wb_fent_q, wb_rent_q;

  logic             conflict_q, conflict_d;
  epoch_t           epoch_q, epoch_d;
  logic             clr_busy_q, clr_busy_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;

  map_entry_t       f_rd, r_rd, f_ent, r_ent;
  map_entry_t       f_wr, r_wr;
  logic             bad_f, bad_r, do_chk, clash, upd, wrap_hold;
  logic             mem_we;
  logic [IDX_W-1:0] f_widx, r_widx;
  logic             verdict, push;

  assign wrap_hold  = s1_vld_q && s1_last_q && (epoch_q == EPOCH_LAST);
  assign in_stall_o = clr_busy_q || wrap_hold || !q_room;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    f_ent   = (wb_vld_q && wb_fidx_q == s1_fidx_q) ? wb_fent_q : f_rd;
    r_ent   = (wb_vld_q && wb_ridx_q == s1_ridx_q) ? wb_rent_q : r_rd;
    bad_f   = (f_ent.epoch == epoch_q) && (f_ent.partner != s1_dst_q);
    bad_r   = (r_ent.epoch == epoch_q) && (r_ent.partner != s1_src_q);
    clash   = bad_f || bad_r;
    do_chk  = s1_vld_q && !conflict_q;
    upd     = do_chk && !clash;
    verdict = !conflict_q && !clash;
    push    = s1_vld_q && s1_last_q;

    conflict_d = conflict_q;
    epoch_d    = epoch_q;
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + IDX_W'(1);
      if (clr_idx_q == IDX_END) begin
        clr_busy_d = 1'b0;
      end
    end
    priority if (push) begin
      conflict_d = 1'b0;
      if (epoch_q == EPOCH_LAST) begin
        epoch_d    = EPOCH_FIRST;
        clr_busy_d = 1'b1;
        clr_idx_d  = '0;
      end else begin
        epoch_d = epoch_q + EPOCH_FIRST;
      end
    end else if (do_chk && clash) begin
      conflict_d = 1'b1;
    end

    mem_we = clr_busy_q || upd;
    if (clr_busy_q) begin
      f_widx = clr_idx_q;
      r_widx = clr_idx_q;
      f_wr   = '{epoch: EPOCH_NONE, partner: '0};
      r_wr   = '{epoch: EPOCH_NONE, partner: '0};
    end else begin
      f_widx = s1_fidx_q;
      r_widx = s1_ridx_q;
      f_wr   = '{epoch: epoch_q, partner: s1_dst_q};
      r_wr   = '{epoch: epoch_q, partner: s1_src_q};
    end
  end

  isp_map_mem #(.DEPTH(SYMBOLS), .IDX_W(IDX_W)) u_fwd_map (
    .clk_i      (clk_i),
    .rd_en_i    (in_acc),
    .rd_idx_i   (idx_lut[src_char_i]),
    .rd_entry_o (f_rd),
    .wr_en_i    (mem_we),
    .wr_idx_i   (f_widx),
    .wr_entry_i (f_wr)
  );

  isp_map_mem #(.DEPTH(SYMBOLS), .IDX_W(IDX_W)) u_rev_map (
    .clk_i      (clk_i),
    .rd_en_i    (in_acc),
    .rd_idx_i   (idx_lut[dst_char_i]),
    .rd_entry_o (r_rd),
    .wr_en_i    (mem_we),
    .wr_idx_i   (r_widx),
    .wr_entry_i (r_wr)
  );

  isp_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (verdict),
    .room_o      (q_room),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .data_o      (is_isomorphic_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      wb_vld_q   <= 1'b0;
      conflict_q <= 1'b0;
      epoch_q    <= EPOCH_FIRST;
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      s1_vld_q   <= in_acc;
      wb_vld_q   <= upd;
      conflict_q <= conflict_d;
      epoch_q    <= epoch_d;
      clr_busy_q <= clr_busy_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_src_q  <= src_char_i;
      s1_dst_q  <= dst_char_i;
      s1_last_q <= last_i;
      s1_fidx_q <= idx_lut[src_char_i];
      s1_ridx_q <= idx_lut[dst_char_i];
    end
    if (upd) begin
      wb_fidx_q <= s1_fidx_q;
      wb_ridx_q <= s1_ridx_q;
      wb_fent_q <= f_wr;
      wb_rent_q <= r_wr;
    end
  end

  // no item may be checked while the clearing pass owns the memories
  a_no_check_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clr_busy_q && s1_vld_q))
    else $error("item in check stage during clearing pass");

  // a wrap pass starts only right after a last item left the check stage
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(clr_busy_q) |-> $past(s1_vld_q && s1_last_q))
    else $error("clearing pass started without a finished string");

  // the conflict flag is cleared for the next string
  a_conflict_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s1_last_q) |=> !conflict_q)
    else $error("conflict flag survived the end of a string");

endmodule

/* rtl/core/isp_map_mem.sv */
// One character map: synchronous memory of epoch-tagged partner entries.
// One read port with registered data, one write port. Depends on isp_pkg.
module isp_map_mem import isp_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned IDX_W = 8
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output map_entry_t       rd_entry_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  map_entry_t       wr_entry_i
);

  map_entry_t mem_q [DEPTH];
  map_entry_t rd_entry_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_entry_o = rd_entry_q;

endmodule

/* rtl/core/isp_out_queue.sv */
// Two-entry verdict queue between the check stage and the output channel.
// Reports whether one more push next cycle still fits. Depends on isp_pkg.
module isp_out_queue import isp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic push_data_i,
  output logic room_o,
  output logic valid_o,
  input  logic stall_i,
  output logic data_o
);

  localparam logic [1:0] LEVEL_FULL = 2'd2;

  logic       data_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = data_q[rd_ptr_q];
  assign pop     = valid_o && !stall_i;

  always_comb begin
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop;
  end

  assign room_o = (cnt_d != LEVEL_FULL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
